[rtl/hiw_pkg.sv]
// Package: widths, image size, register map and pipeline types of the warp address unit.
package hiw_pkg;
	localparam int SRC_WIDTH  = 1024;
	localparam int SRC_HEIGHT = 1024;
	localparam int COEF_W     = 48;
	localparam int COORD_W    = 16;
	localparam int PROD_W     = 64;
	localparam int SUM_W      = 68;
	localparam int DIV_W      = 84;
	localparam int QBITS      = 16;
	localparam int IDX_W      = 20;
	localparam int NREGS      = 8;
	localparam int PADDR_W    = 6;
	localparam int PDATA_W    = 64;

	typedef enum logic [2:0] {
		REG_SX_X  = 3'd0,
		REG_SX_Y  = 3'd1,
		REG_SX_C  = 3'd2,
		REG_SY_X  = 3'd3,
		REG_SY_Y  = 3'd4,
		REG_SY_C  = 3'd5,
		REG_DEN_X = 3'd6,
		REG_DEN_Y = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [DIV_W-1:0] rx;
		logic [DIV_W-1:0] ry;
		logic [DIV_W-1:0] dsh;
		logic [QBITS-1:0] qx;
		logic [QBITS-1:0] qy;
		logic             ovfx;
		logic             ovfy;
		logic             negx;
		logic             negy;
		logic             zero;
	} div_t;
endpackage

[rtl/hiw_in_if.sv]
// Interface: destination coordinate request channel.
interface hiw_in_if import hiw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] dest_x;
	logic [COORD_W-1:0] dest_y;
	modport source (output valid, dest_x, dest_y, input ready);
	modport sink (input valid, dest_x, dest_y, output ready);
endinterface

[rtl/hiw_out_if.sv]
// Interface: source address result channel.
interface hiw_out_if import hiw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] src_x;
	logic [COORD_W-1:0] src_y;
	logic               in_range;
	logic [IDX_W-1:0]   src_index;
	modport source (output valid, src_x, src_y, in_range, src_index, input ready);
	modport sink (input valid, src_x, src_y, in_range, src_index, output ready);
endinterface

[rtl/hiw_div_step.sv]
// One restoring division stage: one quotient bit for both coordinates.
module hiw_div_step import hiw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_v,
	input  div_t in_d,
	output logic in_rdy,
	output logic out_v,
	output div_t out_d,
	input  logic out_rdy
);
	div_t nxt;
	logic [DIV_W-1:0] dn;

	assign in_rdy = !out_v || out_rdy;

	always_comb begin
		nxt = in_d;
		dn = in_d.dsh >> 1;
		nxt.dsh = dn;
		if (in_d.rx >= dn) begin
			nxt.rx = in_d.rx - dn;
			nxt.qx = {in_d.qx[QBITS-2:0], 1'b1};
		end else begin
			nxt.qx = {in_d.qx[QBITS-2:0], 1'b0};
		end
		if (in_d.ry >= dn) begin
			nxt.ry = in_d.ry - dn;
			nxt.qy = {in_d.qy[QBITS-2:0], 1'b1};
		end else begin
			nxt.qy = {in_d.qy[QBITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (in_rdy) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_v) begin
			out_d <= nxt;
		end
	end
endmodule

[rtl/homography_inverse_warp_address_unit.sv]
// Top level: homography inverse-warp nearest-neighbor source address pipeline.
//   channel | dir | handshake          | payload
//   coord   | in  | valid/ready        | dest_x, dest_y
//   fetch   | out | valid/ready        | src_x, src_y, in_range, src_index
//   apb     | in  | psel/penable/pready| 8 x 48-bit coefficients at 8*i
// One request per clock unless fetch.ready stalls; stages: multiply, sum, sign fix, overflow
// test, 16 restoring divide stages (one quotient bit each), saturate/index.
// Reset clears all valid bits and loads the identity matrix.
// Each stage holds while its successor is full and stalled; bubbles collapse.
module homography_inverse_warp_address_unit import hiw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	hiw_in_if.sink             coord,
	hiw_out_if.source          fetch
);
	logic [COEF_W-1:0] coef_q [NREGS];
	reg_idx_t widx;

	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign prdata = {{(PDATA_W-COEF_W){1'b0}}, coef_q[paddr[PADDR_W-1:3]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) coef_q[i] <= '0;
			coef_q[REG_SX_X] <= 48'h0001_0000_0000;
			coef_q[REG_SY_Y] <= 48'h0001_0000_0000;
		end else if (psel && penable && pwrite && pready) begin
			coef_q[widx] <= pwdata[COEF_W-1:0];
		end
	end

	// stage 1: products
	logic v_s1, en1;
	logic signed [PROD_W-1:0] pdx_s1, pdy_s1, pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	// stage 2: sums
	logic v_s2, en2;
	logic signed [SUM_W-1:0] d_s2, nx_s2, ny_s2;
	// stage 3: rounding numerators
	logic v_s3, en3;
	logic [DIV_W-1:0] ax_s3, ay_s3, den_s3;
	logic negx_s3, negy_s3, zero_s3;
	// stage 4: overflow test
	logic v_s4, en4;
	div_t d_s4;
	// output stage
	logic en_o;

	localparam int NDIV = QBITS;
	logic dv   [NDIV+1];
	div_t dd   [NDIV+1];
	logic drdy [NDIV+1];

	assign en_o = !fetch.valid || fetch.ready;
	assign en4  = !v_s4 || drdy[0];
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign coord.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= coord.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && coord.valid) begin
			pdx_s1 <= $signed(coef_q[REG_DEN_X]) * $signed(coord.dest_x);
			pdy_s1 <= $signed(coef_q[REG_DEN_Y]) * $signed(coord.dest_y);
			pxx_s1 <= $signed(coef_q[REG_SX_X]) * $signed(coord.dest_x);
			pxy_s1 <= $signed(coef_q[REG_SX_Y]) * $signed(coord.dest_y);
			pyx_s1 <= $signed(coef_q[REG_SY_X]) * $signed(coord.dest_x);
			pyy_s1 <= $signed(coef_q[REG_SY_Y]) * $signed(coord.dest_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			d_s2  <= SUM_W'(pdx_s1) + SUM_W'(pdy_s1) + SUM_W'(64'sh1_0000_0000);
			nx_s2 <= SUM_W'(pxx_s1) + SUM_W'(pxy_s1) + SUM_W'($signed(coef_q[REG_SX_C]));
			ny_s2 <= SUM_W'(pyx_s1) + SUM_W'(pyy_s1) + SUM_W'($signed(coef_q[REG_SY_C]));
		end
	end

	// sign fix, then floor(n/d + 1/2) = floor((2n + d) / 2d)
	logic signed [SUM_W-1:0] dp, nxp, nyp, numx, numy, den2;
	logic [DIV_W-1:0] ax, ay;
	always_comb begin
		dp  = d_s2[SUM_W-1] ? -d_s2  : d_s2;
		nxp = d_s2[SUM_W-1] ? -nx_s2 : nx_s2;
		nyp = d_s2[SUM_W-1] ? -ny_s2 : ny_s2;
		den2 = dp <<< 1;
		numx = (nxp <<< 1) + dp;
		numy = (nyp <<< 1) + dp;
		ax = numx[SUM_W-1] ? DIV_W'(-numx + den2 - SUM_W'(1)) : DIV_W'(numx);
		ay = numy[SUM_W-1] ? DIV_W'(-numy + den2 - SUM_W'(1)) : DIV_W'(numy);
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			ax_s3   <= ax;
			ay_s3   <= ay;
			den_s3  <= DIV_W'(den2);
			negx_s3 <= numx[SUM_W-1];
			negy_s3 <= numy[SUM_W-1];
			zero_s3 <= (d_s2 == '0);
		end
	end

	logic [DIV_W-1:0] dsh;
	assign dsh = den_s3 << QBITS;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			d_s4.rx   <= ax_s3;
			d_s4.ry   <= ay_s3;
			d_s4.dsh  <= dsh;
			d_s4.qx   <= '0;
			d_s4.qy   <= '0;
			d_s4.ovfx <= ax_s3 >= dsh;
			d_s4.ovfy <= ay_s3 >= dsh;
			d_s4.negx <= negx_s3;
			d_s4.negy <= negy_s3;
			d_s4.zero <= zero_s3;
		end
	end

	assign dv[0] = v_s4;
	assign dd[0] = d_s4;
	assign drdy[NDIV] = en_o;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		hiw_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (dv[g]),
			.in_d    (dd[g]),
			.in_rdy  (drdy[g]),
			.out_v   (dv[g+1]),
			.out_d   (dd[g+1]),
			.out_rdy (drdy[g+1])
		);
	end

	// saturate, range check, linear index
	div_t fin;
	logic [COORD_W-1:0] sx, sy;
	logic ok;
	logic [31:0] lin;
	always_comb begin
		fin = dd[NDIV];
		if (fin.zero) begin
			sx = '0;
		end else if (!fin.negx) begin
			sx = (fin.ovfx || fin.qx > 16'd32767) ? 16'h7fff : fin.qx;
		end else begin
			sx = (fin.ovfx || fin.qx > 16'd32768) ? 16'h8000 : -fin.qx;
		end
		if (fin.zero) begin
			sy = '0;
		end else if (!fin.negy) begin
			sy = (fin.ovfy || fin.qy > 16'd32767) ? 16'h7fff : fin.qy;
		end else begin
			sy = (fin.ovfy || fin.qy > 16'd32768) ? 16'h8000 : -fin.qy;
		end
		ok = !fin.zero && !sx[15] && (sx[14:0] < 15'(SRC_WIDTH))
			&& !sy[15] && (sy[14:0] < 15'(SRC_HEIGHT));
		lin = 32'(sy[14:0]) * 32'(SRC_WIDTH) + 32'(sx[14:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch.valid <= 1'b0;
		end else if (en_o) begin
			fetch.valid <= dv[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && dv[NDIV]) begin
			fetch.src_x     <= sx;
			fetch.src_y     <= sy;
			fetch.in_range  <= ok;
			fetch.src_index <= ok ? lin[IDX_W-1:0] : '0;
		end
	end
endmodule
